// ===== design/pngu_pkg.sv =====
package pngu_pkg;

	// Sizing defaults for the top level parameters
	localparam int LINE_MAX_DEF = 4096;
	localparam int STEP_MAX_DEF = 8;

	// Fixed field widths
	localparam int BYTE_W      = 8;
	localparam int FILT_W      = 3;
	localparam int LEN_REG_W   = 13;
	localparam int STEP_REG_W  = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;

	// Filter type codes
	localparam logic [FILT_W-1:0] FILT_NONE    = 3'd0;
	localparam logic [FILT_W-1:0] FILT_SUB     = 3'd1;
	localparam logic [FILT_W-1:0] FILT_UP      = 3'd2;
	localparam logic [FILT_W-1:0] FILT_AVERAGE = 3'd3;
	localparam logic [FILT_W-1:0] FILT_PAETH   = 3'd4;

	// Largest legal filter byte
	localparam logic [BYTE_W-1:0] FILT_LAST_CODE = 8'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = 2'd1;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== design/pngu_if.sv =====
interface pngu_stream_if;
	logic                       valid;
	logic                       ready;
	logic [pngu_pkg::BYTE_W-1:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

interface pngu_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [pngu_pkg::BYTE_W-1:0] pixel_byte;
	logic                       line_end;
	logic                       bad_filter;

	modport source (output valid, output pixel_byte, output line_end, output bad_filter,
		input ready);
	modport sink   (input valid, input pixel_byte, input line_end, input bad_filter,
		output ready);
endinterface

interface pngu_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pngu_pkg::CFG_IDX_W-1:0]  index;
	logic [pngu_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/pngu_predict.sv =====
module pngu_predict (
	input  logic [pngu_pkg::FILT_W-1:0] filt,
	input  pngu_pkg::byte_t             a,
	input  pngu_pkg::byte_t             b,
	input  pngu_pkg::byte_t             c,
	output pngu_pkg::byte_t             pred
);
	import pngu_pkg::*;

	logic [BYTE_W:0]   avg_sum;
	logic signed [10:0] sa, sb, sc;
	logic signed [10:0] da, db, dc;
	logic [10:0]       pa, pb, pc;
	byte_t             paeth;

	// Distances to the Paeth estimate a + b - c
	always_comb begin
		sa = signed'({3'b000, a});
		sb = signed'({3'b000, b});
		sc = signed'({3'b000, c});
		da = sb - sc;
		db = sa - sc;
		dc = sa + sb - (sc <<< 1);
		pa = da[10] ? 11'(-da) : 11'(da);
		pb = db[10] ? 11'(-db) : 11'(db);
		pc = dc[10] ? 11'(-dc) : 11'(dc);
		priority if (pa <= pb && pa <= pc) begin
			paeth = a;
		end else if (pb <= pc) begin
			paeth = b;
		end else begin
			paeth = c;
		end
	end

	assign avg_sum = {1'b0, a} + {1'b0, b};

	// Select the predictor of the line's filter
	always_comb begin
		unique case (filt)
			FILT_SUB:     pred = a;
			FILT_UP:      pred = b;
			FILT_AVERAGE: pred = avg_sum[BYTE_W:1];
			FILT_PAETH:   pred = paeth;
			default:      pred = '0;
		endcase
	end

endmodule

// ===== design/png_scanline_unfilter.sv =====
// PNG scanline unfilter, filter method 0 (None, Sub, Up, Average, Paeth).
// stream: one inflated image byte per word. The first word of each line is
//   the filter type, giving no output word unless bad; the next line_bytes
//   words are filtered bytes, each giving one reconstructed byte on pixel.
// pixel: reconstructed byte with line_end on the last byte of a line. A filter
//   type above 4 gives one word with bad_filter set (byte and line_end zero)
//   and that line is reconstructed as None.
// cfg: register 0 is line_bytes, register 1 is pixel_step; always ready; the
//   user must see it is written only while no words are in flight (unchecked).
// Throughput is one byte per cycle while pixel is ready. An accepted byte
// reads the previous line buffer at its column into the read stage; when
// that stage moves on, it forms the prediction and the sum, writes the
// reconstructed byte back to the buffer and loads the output register.
// A stalled receiver holds the output register; one more byte is then held
// in the read stage, after which stream.ready drops.
// Reset clears the column, the filter, both histories and the output
// valid. The line buffer is not cleared: the first line after reset uses zero
// for the bytes above, and later lines read only entries already written.
module png_scanline_unfilter #(
	parameter int LINE_MAX = pngu_pkg::LINE_MAX_DEF,
	parameter int STEP_MAX = pngu_pkg::STEP_MAX_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pngu_stream_if.sink  stream,
	pngu_pixel_if.source pixel,
	pngu_cfg_if.sink     cfg
);
	import pngu_pkg::*;

	localparam int CW = $clog2(LINE_MAX + 1);
	localparam int AW = $clog2(LINE_MAX);
	localparam int LW = (CW > LEN_REG_W) ? CW : LEN_REG_W;
	localparam int TW = (STEP_MAX > 1) ? $clog2(STEP_MAX) : 1;

	// Configuration
	logic [LEN_REG_W-1:0]  line_bytes_q;
	logic [STEP_REG_W-1:0] pixel_step_q;

	// Line tracking at the accept side
	logic [CW-1:0]     col_q;
	logic [FILT_W-1:0] filt_q;
	logic              first_q;

	// Read stage
	logic              v_s1;
	logic              hdr_s1;
	logic              bad_s1;
	logic              last_s1;
	logic              first_s1;
	logic [FILT_W-1:0] filt_s1;
	logic [AW-1:0]     x_s1;
	byte_t             byte_s1;
	byte_t             rdata_s1;

	// Histories and line buffer
	byte_t lhist_q [STEP_MAX];
	byte_t uhist_q [STEP_MAX];
	byte_t above_mem [LINE_MAX];

	// Output register
	logic  o_valid_q;
	byte_t o_byte_q;
	logic  o_end_q;
	logic  o_bad_q;

	logic              acc;
	logic              s1_adv;
	logic              is_hdr;
	logic              is_bad;
	logic              is_last;
	logic [LW-1:0]     len_raw;
	logic [LW-1:0]     len_eff;
	logic [AW-1:0]     rd_addr;
	logic [STEP_REG_W-1:0] step_eff;
	logic [TW-1:0]     tap;
	byte_t             a, b, c, pred, res;

	assign cfg.ready = 1'b1;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q <= LEN_REG_W'(1);
			pixel_step_q <= STEP_REG_W'(1);
		end else if (cfg.valid) begin
			if (cfg.index == REG_LINE_BYTES) begin
				line_bytes_q <= cfg.data[LEN_REG_W-1:0];
			end else if (cfg.index == REG_PIXEL_STEP) begin
				pixel_step_q <= cfg.data[STEP_REG_W-1:0];
			end
		end
	end

	// Clamp line length and pixel step
	always_comb begin
		len_raw = LW'(line_bytes_q);
		priority if (len_raw == '0) begin
			len_eff = LW'(1);
		end else if (len_raw > LW'(LINE_MAX)) begin
			len_eff = LW'(LINE_MAX);
		end else begin
			len_eff = len_raw;
		end
		priority if (pixel_step_q == '0) begin
			step_eff = STEP_REG_W'(1);
		end else if (pixel_step_q > STEP_REG_W'(STEP_MAX)) begin
			step_eff = STEP_REG_W'(STEP_MAX);
		end else begin
			step_eff = pixel_step_q;
		end
	end

	// Handshake
	assign s1_adv       = !o_valid_q || pixel.ready;
	assign stream.ready = !v_s1 || s1_adv;
	assign acc          = stream.valid && stream.ready;

	assign is_hdr  = (col_q == '0);
	assign is_bad  = (stream.stream_byte > FILT_LAST_CODE);
	assign is_last = (LW'(col_q) >= len_eff);
	assign rd_addr = AW'(col_q - CW'(1));

	// Advance the column on every accepted word, load the filter at filter bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			filt_q  <= FILT_NONE;
			first_q <= 1'b1;
		end else if (acc) begin
			if (is_hdr) begin
				col_q  <= CW'(1);
				filt_q <= is_bad ? FILT_NONE : stream.stream_byte[FILT_W-1:0];
			end else if (is_last) begin
				col_q   <= '0;
				first_q <= 1'b0;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Read stage valid: fill on accept, empty when it moves on, else hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc || s1_adv) begin
			v_s1 <= acc;
		end
	end

	// Read stage payload
	always_ff @(posedge clk) begin
		if (acc) begin
			hdr_s1   <= is_hdr;
			bad_s1   <= is_hdr && is_bad;
			last_s1  <= !is_hdr && is_last;
			first_s1 <= first_q;
			filt_s1  <= filt_q;
			x_s1     <= rd_addr;
			byte_s1  <= stream.stream_byte;
		end
	end

	// Line buffer: read on accept, write back the reconstructed byte
	always_ff @(posedge clk) begin
		if (s1_adv && v_s1 && !hdr_s1) begin
			above_mem[x_s1] <= res;
		end
		if (acc) begin
			rdata_s1 <= above_mem[rd_addr];
		end
	end

	// Reconstruct
	assign tap = TW'(step_eff - STEP_REG_W'(1));
	assign a   = lhist_q[tap];
	assign c   = uhist_q[tap];
	assign b   = first_s1 ? '0 : rdata_s1;

	pngu_predict u_predict (
		.filt (filt_s1),
		.a    (a),
		.b    (b),
		.c    (c),
		.pred (pred)
	);

	assign res = byte_s1 + pred;

	// Shift histories on pixel bytes, drop them at each filter byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STEP_MAX; i++) begin
				lhist_q[i] <= '0;
				uhist_q[i] <= '0;
			end
		end else if (s1_adv && v_s1) begin
			if (hdr_s1) begin
				for (int i = 0; i < STEP_MAX; i++) begin
					lhist_q[i] <= '0;
					uhist_q[i] <= '0;
				end
			end else begin
				for (int i = STEP_MAX - 1; i > 0; i--) begin
					lhist_q[i] <= lhist_q[i-1];
					uhist_q[i] <= uhist_q[i-1];
				end
				lhist_q[0] <= res;
				uhist_q[0] <= b;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (s1_adv) begin
			o_valid_q <= v_s1 && (!hdr_s1 || bad_s1);
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (s1_adv && v_s1) begin
			o_byte_q <= hdr_s1 ? '0 : res;
			o_end_q  <= last_s1;
			o_bad_q  <= bad_s1;
		end
	end

	assign pixel.valid      = o_valid_q;
	assign pixel.pixel_byte = o_byte_q;
	assign pixel.line_end   = o_end_q;
	assign pixel.bad_filter = o_bad_q;

endmodule

// ===== design/pngu_checker.sv =====
module pngu_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [pngu_pkg::BYTE_W-1:0] out_byte,
	input logic                   out_end,
	input logic                   out_bad,
	input logic                   in_valid,
	input logic                   in_ready
);
	import pngu_pkg::*;

	// No word leaves while reset is applied
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output word shown during reset");

	// A bad filter word carries no byte and ends no line
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_bad) |-> (out_byte == '0 && !out_end))
		else $error("bad filter word with byte or line end");

	// A stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_byte) &&
			$stable(out_end) && $stable(out_bad)))
		else $error("stalled output word changed");

	// With the receiver taking every word, the input is never refused
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ready && $past(out_ready)) |-> in_ready)
		else $error("input refused while output flows");

	// An output word needs an input word accepted before it
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output word without an accepted input word");

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (pixel.valid),
	.out_ready (pixel.ready),
	.out_byte  (pixel.pixel_byte),
	.out_end   (pixel.line_end),
	.out_bad   (pixel.bad_filter),
	.in_valid  (stream.valid),
	.in_ready  (stream.ready)
);
